// File: src/clipped_rect_fill_span_engine_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the clipped rectangle fill span engine
// Shared property wrappers used by the port checker.
// ---------------------------------------------------------------------------
`ifndef CLIPPED_RECT_FILL_SPAN_ENGINE_TOP_ASSERT_SVH
`define CLIPPED_RECT_FILL_SPAN_ENGINE_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define CRFSE_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define CRFSE_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/crfse_pkg.sv
// ---------------------------------------------------------------------------
// crfse_pkg
// Types, codes and constants of the clipped rectangle fill span engine.
// ---------------------------------------------------------------------------
package crfse_pkg;

  localparam int unsigned DIM_W  = 13;
  localparam int unsigned CLIP_W = 19;

  localparam logic [DIM_W-1:0] SCREEN_MAX = DIM_W'(4096);
  localparam logic signed [CLIP_W-1:0] CLIP_ONE = CLIP_W'(1);

  typedef enum logic [1:0] {
    OP_FILL    = 2'd0,
    OP_OUTLINE = 2'd1,
    OP_ADVANCE = 2'd2,
    OP_NONE    = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1,
    REG_ROW_PITCH     = 2'd2,
    REG_FRAME_BASE    = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_FILL   = 3'd1,
    PH_TOP    = 3'd2,
    PH_BOTTOM = 3'd3,
    PH_LEFT   = 3'd4,
    PH_RIGHT  = 3'd5
  } phase_e;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] w;
    logic signed [15:0] h;
  } rect_t;

  typedef struct packed {
    logic [DIM_W-1:0] row;
    logic [DIM_W-1:0] last_row;
    logic [DIM_W-1:0] col;
    logic [DIM_W-1:0] pixels;
  } shape_t;

  typedef struct packed {
    logic   ok;
    shape_t shape;
  } clip_t;

  typedef struct packed {
    logic        accepted;
    logic        span_valid;
    logic [31:0] span_address;
    logic [DIM_W-1:0] span_length;
    logic [15:0] span_color;
    logic        last;
  } result_t;

  localparam logic [3:0] PAL_MASK = 4'h0F;

  localparam logic [15:0] PALETTE [16] = '{
    16'h0000, 16'h001F, 16'h07E0, 16'h07FF, 16'hF800, 16'hF81F, 16'hA145, 16'hC618,
    16'h4208, 16'h3C7F, 16'h87E0, 16'h87FF, 16'hFC10, 16'hFC1F, 16'hFFE0, 16'hFFFF
  };

endpackage

// File: src/crfse_clip.sv
// ---------------------------------------------------------------------------
// crfse_clip
// Clips one signed shape against the screen and yields its row range and span.
// ---------------------------------------------------------------------------
module crfse_clip import crfse_pkg::*; (
  input  logic signed [CLIP_W-1:0] x_i,
  input  logic signed [CLIP_W-1:0] y_i,
  input  logic signed [CLIP_W-1:0] w_i,
  input  logic signed [CLIP_W-1:0] h_i,
  input  logic [DIM_W-1:0]         sw_i,
  input  logic [DIM_W-1:0]         sh_i,
  output clip_t                    clip_o
);

  logic signed [CLIP_W-1:0] x, y, w, h, swx, shx, y_last;

  assign swx = $signed(CLIP_W'(sw_i));
  assign shx = $signed(CLIP_W'(sh_i));

  always_comb begin
    x = x_i;
    y = y_i;
    w = w_i;
    h = h_i;
    if (x < 0) begin
      w = w + x;
      x = '0;
    end
    if (y < 0) begin
      h = h + y;
      y = '0;
    end
    if (x + w > swx) begin
      w = swx - x;
    end
    if (y + h > shx) begin
      h = shx - y;
    end
  end

  assign y_last = y + h - CLIP_ONE;

  assign clip_o.ok             = (w > 0) && (h > 0);
  assign clip_o.shape.row      = y[DIM_W-1:0];
  assign clip_o.shape.last_row = y_last[DIM_W-1:0];
  assign clip_o.shape.col      = x[DIM_W-1:0];
  assign clip_o.shape.pixels   = w[DIM_W-1:0];

endmodule

// File: src/crfse_edge_seek.sv
// ---------------------------------------------------------------------------
// crfse_edge_seek
// Clips the four outline edges in parallel and picks the first non-empty one
// at or after a given phase.
// ---------------------------------------------------------------------------
module crfse_edge_seek import crfse_pkg::*; (
  input  rect_t            rect_i,
  input  phase_e           from_i,
  input  logic [DIM_W-1:0] sw_i,
  input  logic [DIM_W-1:0] sh_i,
  output logic             found_o,
  output phase_e           phase_o,
  output shape_t           shape_o
);

  localparam phase_e EDGE_PH [4] = '{PH_TOP, PH_BOTTOM, PH_LEFT, PH_RIGHT};

  logic signed [CLIP_W-1:0] x, y, w, h, y_bot, x_rgt;
  logic signed [CLIP_W-1:0] ex [4];
  logic signed [CLIP_W-1:0] ey [4];
  logic signed [CLIP_W-1:0] ew [4];
  logic signed [CLIP_W-1:0] eh [4];
  clip_t                    ec [4];

  assign x     = CLIP_W'(rect_i.x);
  assign y     = CLIP_W'(rect_i.y);
  assign w     = CLIP_W'(rect_i.w);
  assign h     = CLIP_W'(rect_i.h);
  assign y_bot = y + h - CLIP_ONE;
  assign x_rgt = x + w - CLIP_ONE;

  // top, bottom, left, right
  assign ex[0] = x;     assign ey[0] = y;     assign ew[0] = w;        assign eh[0] = CLIP_ONE;
  assign ex[1] = x;     assign ey[1] = y_bot; assign ew[1] = w;        assign eh[1] = CLIP_ONE;
  assign ex[2] = x;     assign ey[2] = y;     assign ew[2] = CLIP_ONE; assign eh[2] = h;
  assign ex[3] = x_rgt; assign ey[3] = y;     assign ew[3] = CLIP_ONE; assign eh[3] = h;

  for (genvar i = 0; i < 4; i++) begin : g_edge
    crfse_clip u_clip (
      .x_i    (ex[i]),
      .y_i    (ey[i]),
      .w_i    (ew[i]),
      .h_i    (eh[i]),
      .sw_i   (sw_i),
      .sh_i   (sh_i),
      .clip_o (ec[i])
    );
  end

  always_comb begin
    found_o = 1'b0;
    phase_o = PH_IDLE;
    shape_o = ec[3].shape;
    for (int i = 3; i >= 0; i--) begin
      if (ec[i].ok && (EDGE_PH[i] >= from_i)) begin
        found_o = 1'b1;
        phase_o = EDGE_PH[i];
        shape_o = ec[i].shape;
      end
    end
  end

endmodule

// File: src/clipped_rect_fill_span_engine_top.sv
// A word accepted at the input passes through the input register, then the result
// register, where it is offered as a result word until it is taken.
// Throughput: one word per cycle; the input register frees whenever the result
// register is empty or is being taken.
// Reset: idle, 640 x 480 screen, pitch 640, frame base 0, both registers empty.
// ---------------------------------------------------------------------------
// clipped_rect_fill_span_engine_top
// Rectangle fill and outline engine emitting one clipped row span per advance.
// ---------------------------------------------------------------------------
module clipped_rect_fill_span_engine_top import crfse_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [31:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          opcode_i,
  input  logic signed [15:0]  x_left_i,
  input  logic signed [15:0]  y_top_i,
  input  logic signed [15:0]  rect_width_i,
  input  logic signed [15:0]  rect_height_i,
  input  logic [7:0]          color_index_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                accepted_o,
  output logic                span_valid_o,
  output logic [31:0]         span_address_o,
  output logic [DIM_W-1:0]    span_length_o,
  output logic [15:0]         span_color_o,
  output logic                last_o
);

  // configuration
  logic [DIM_W-1:0] scr_w_q, scr_h_q, sw_clamp, sh_clamp;
  logic [15:0]      pitch_q;
  logic [31:0]      base_q;

  // input register
  logic       in_valid_q;
  opcode_e    op_q;
  rect_t      rect_q;
  logic [3:0] cidx_q;

  // engine state
  phase_e           phase_q, phase_d;
  logic [DIM_W-1:0] cur_row_q, cur_row_d, last_row_q, last_row_d;
  logic [DIM_W-1:0] col_q, col_d, pix_q, pix_d;
  logic [15:0]      color_q, color_d;
  rect_t            saved_q, saved_d;

  // result register
  logic    out_valid_q;
  result_t res_q, res_d;

  logic    proc, is_start, row_done;
  clip_t   fill_clip;
  rect_t   seek_rect;
  phase_e  seek_from;
  logic    seek_found;
  phase_e  seek_phase;
  shape_t  seek_shape;
  logic [DIM_W+15:0] row_off;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_w_q <= DIM_W'(640);
      scr_h_q <= DIM_W'(480);
      pitch_q <= 16'd640;
      base_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_SCREEN_WIDTH:  scr_w_q <= cfg_wdata_i[DIM_W-1:0];
        REG_SCREEN_HEIGHT: scr_h_q <= cfg_wdata_i[DIM_W-1:0];
        REG_ROW_PITCH:     pitch_q <= cfg_wdata_i[15:0];
        REG_FRAME_BASE:    base_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign sw_clamp = (scr_w_q > SCREEN_MAX) ? SCREEN_MAX : scr_w_q;
  assign sh_clamp = (scr_h_q > SCREEN_MAX) ? SCREEN_MAX : scr_h_q;

  assign proc       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (proc) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q   <= opcode_e'(opcode_i);
      rect_q <= '{x: x_left_i, y: y_top_i, w: rect_width_i, h: rect_height_i};
      cidx_q <= color_index_i[3:0] & PAL_MASK;
    end
  end

  assign is_start = (op_q == OP_FILL) || (op_q == OP_OUTLINE);
  assign row_done = cur_row_q >= last_row_q;

  crfse_clip u_fill_clip (
    .x_i    (CLIP_W'(rect_q.x)),
    .y_i    (CLIP_W'(rect_q.y)),
    .w_i    (CLIP_W'(rect_q.w)),
    .h_i    (CLIP_W'(rect_q.h)),
    .sw_i   (sw_clamp),
    .sh_i   (sh_clamp),
    .clip_o (fill_clip)
  );

  assign seek_rect = is_start ? rect_q : saved_q;
  assign seek_from = is_start ? PH_TOP : phase_e'(phase_q + 3'd1);

  crfse_edge_seek u_edge_seek (
    .rect_i  (seek_rect),
    .from_i  (seek_from),
    .sw_i    (sw_clamp),
    .sh_i    (sh_clamp),
    .found_o (seek_found),
    .phase_o (seek_phase),
    .shape_o (seek_shape)
  );

  // next state
  always_comb begin
    phase_d    = phase_q;
    cur_row_d  = cur_row_q;
    last_row_d = last_row_q;
    col_d      = col_q;
    pix_d      = pix_q;
    color_d    = color_q;
    saved_d    = saved_q;
    case (op_q)
      OP_FILL, OP_OUTLINE: begin
        if (phase_q == PH_IDLE) begin
          color_d = PALETTE[cidx_q];
          saved_d = rect_q;
          if (op_q == OP_FILL) begin
            if (fill_clip.ok) begin
              phase_d    = PH_FILL;
              cur_row_d  = fill_clip.shape.row;
              last_row_d = fill_clip.shape.last_row;
              col_d      = fill_clip.shape.col;
              pix_d      = fill_clip.shape.pixels;
            end
          end else if (seek_found) begin
            phase_d    = seek_phase;
            cur_row_d  = seek_shape.row;
            last_row_d = seek_shape.last_row;
            col_d      = seek_shape.col;
            pix_d      = seek_shape.pixels;
          end
        end
      end
      OP_ADVANCE: begin
        if (phase_q != PH_IDLE) begin
          if (!row_done) begin
            cur_row_d = cur_row_q + DIM_W'(1);
          end else if (phase_q == PH_FILL || phase_q == PH_RIGHT || !seek_found) begin
            phase_d = PH_IDLE;
          end else begin
            phase_d    = seek_phase;
            cur_row_d  = seek_shape.row;
            last_row_d = seek_shape.last_row;
            col_d      = seek_shape.col;
            pix_d      = seek_shape.pixels;
          end
        end
      end
      default: ;
    endcase
  end

  assign row_off = cur_row_q * pitch_q;

  // result word
  always_comb begin
    res_d = '0;
    case (op_q)
      OP_FILL, OP_OUTLINE: begin
        if (phase_q == PH_IDLE) begin
          res_d.accepted = 1'b1;
          res_d.last     = (op_q == OP_FILL) ? !fill_clip.ok : !seek_found;
        end
      end
      OP_ADVANCE: begin
        if (phase_q != PH_IDLE) begin
          res_d.span_valid   = 1'b1;
          res_d.span_address = base_q + 32'(row_off) + 32'(col_q);
          res_d.span_length  = pix_q;
          res_d.span_color   = color_q;
          res_d.last         = row_done &&
                               (phase_q == PH_FILL || phase_q == PH_RIGHT || !seek_found);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      cur_row_q  <= '0;
      last_row_q <= '0;
      col_q      <= '0;
      pix_q      <= '0;
      color_q    <= '0;
      saved_q    <= '0;
    end else if (proc) begin
      phase_q    <= phase_d;
      cur_row_q  <= cur_row_d;
      last_row_q <= last_row_d;
      col_q      <= col_d;
      pix_q      <= pix_d;
      color_q    <= color_d;
      saved_q    <= saved_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign accepted_o     = res_q.accepted;
  assign span_valid_o   = res_q.span_valid;
  assign span_address_o = res_q.span_address;
  assign span_length_o  = res_q.span_length;
  assign span_color_o   = res_q.span_color;
  assign last_o         = res_q.last;

endmodule

// File: src/crfse_checker.sv
// ---------------------------------------------------------------------------
// crfse_checker
// Port-level checks on the result channel of the span engine, bound to the top.
// ---------------------------------------------------------------------------
`include "clipped_rect_fill_span_engine_top_assert.svh"

module crfse_checker import crfse_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic             accepted_o,
  input logic             span_valid_o,
  input logic [31:0]      span_address_o,
  input logic [DIM_W-1:0] span_length_o,
  input logic [15:0]      span_color_o,
  input logic             last_o
);

  `CRFSE_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o, "result word dropped while stalled")

  `CRFSE_ASSERT_IMP(a_span_shape, clk_i, rst_ni, out_valid_o && span_valid_o, !accepted_o && span_length_o != '0 && span_length_o <= SCREEN_MAX, "bad span word")

  `CRFSE_ASSERT_IMP(a_nospan_zero, clk_i, rst_ni, out_valid_o && !span_valid_o, span_address_o == '0 && span_length_o == '0 && span_color_o == '0, "span fields set without span")

  `CRFSE_ASSERT_IMP(a_noop_not_last, clk_i, rst_ni, out_valid_o && !span_valid_o && !accepted_o, !last_o, "empty word marked last")

endmodule

bind clipped_rect_fill_span_engine_top crfse_checker u_crfse_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .accepted_o     (accepted_o),
  .span_valid_o   (span_valid_o),
  .span_address_o (span_address_o),
  .span_length_o  (span_length_o),
  .span_color_o   (span_color_o),
  .last_o         (last_o)
);
